### rtl/assert_macros.svh
// assertion macros shared by the command decoder rtl
// no dependencies; simulation builds get checks, synthesis builds get nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCD_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define SCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCD_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

### rtl/scd_pkg.sv
// shared widths, command codes and reply tables for the command decoder
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package scd_pkg;

  // system constants
  localparam longint unsigned CLOCK_HZ   = 100000000;
  localparam longint unsigned SAMPLE_CAP = 16777216;
  localparam longint unsigned NS_PER_S   = 1000000000;
  localparam longint unsigned NS_PER_MS  = 1000000;

  // field widths
  localparam int RX_W   = 8;
  localparam int TX_W   = 8;
  localparam int RATE_W = 28;
  localparam int CNT_W  = 25;
  localparam int WIN_W  = 40;
  localparam int CFG_W  = 20;

  localparam logic [CFG_W-1:0]  MAX_WIN_RESET = 20'd10000;
  localparam logic [RATE_W-1:0] RATE_MAX      = '1;

  // host command codes
  localparam logic [7:0] CMD_RESET   = 8'h00;
  localparam logic [7:0] CMD_RUN     = 8'h01;
  localparam logic [7:0] CMD_ID      = 8'h02;
  localparam logic [7:0] CMD_META    = 8'h04;
  localparam logic [7:0] CMD_QUERY   = 8'h06;
  localparam logic [7:0] CMD_DIVIDER = 8'h80;
  localparam logic [7:0] CMD_READ16  = 8'h81;
  localparam logic [7:0] CMD_FLAGS   = 8'h82;
  localparam logic [7:0] CMD_READ32  = 8'h84;

  // reply stream lengths
  localparam int ID_LEN   = 4;
  localparam int META_LEN = 40;

  // id reply bytes
  function automatic logic [7:0] id_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h31;
      2'd1:    b = 8'h41;
      2'd2:    b = 8'h4C;
      default: b = 8'h53;
    endcase
    return b;
  endfunction

  // metadata reply bytes
  function automatic logic [7:0] meta_byte(input logic [5:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0:    b = 8'h01;
      6'd1:    b = 8'h65;
      6'd2:    b = 8'h64;
      6'd3:    b = 8'h74;
      6'd4:    b = 8'h2D;
      6'd5:    b = 8'h73;
      6'd6:    b = 8'h75;
      6'd7:    b = 8'h6D;
      6'd8:    b = 8'h70;
      6'd9:    b = 8'h00;
      6'd10:   b = 8'h02;
      6'd11:   b = 8'h31;
      6'd12:   b = 8'h2E;
      6'd13:   b = 8'h30;
      6'd14:   b = 8'h00;
      6'd15:   b = 8'h20;
      6'd16:   b = 8'h00;
      6'd17:   b = 8'h00;
      6'd18:   b = 8'h00;
      6'd19:   b = 8'h08;
      6'd20:   b = 8'h21;
      6'd21:   b = 8'h00;
      6'd22:   b = 8'h40;
      6'd23:   b = 8'h00;
      6'd24:   b = 8'h00;
      6'd25:   b = 8'h23;
      6'd26:   b = 8'h00;
      6'd27:   b = 8'h1E;
      6'd28:   b = 8'h84;
      6'd29:   b = 8'h80;
      6'd30:   b = 8'h24;
      6'd31:   b = 8'h00;
      6'd32:   b = 8'h00;
      6'd33:   b = 8'h00;
      6'd34:   b = 8'h02;
      6'd35:   b = 8'h40;
      6'd36:   b = 8'h08;
      6'd37:   b = 8'h41;
      6'd38:   b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/scd_channels.sv
// valid/ready channel interfaces for host bytes in and results out
// depends on scd_pkg for the field widths
`timescale 1ns / 1ps

interface sump_in_if;
  import scd_pkg::*;
  logic            valid;
  logic            ready;
  logic [RX_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sump_out_if;
  import scd_pkg::*;
  logic              valid;
  logic              ready;
  logic              out_kind;
  logic [TX_W-1:0]   tx_byte;
  logic [RATE_W-1:0] sample_rate_hz;
  logic [CNT_W-1:0]  sample_count;
  logic [WIN_W-1:0]  acq_span_ns;
  logic              last_of_run;
  modport source (output valid, output out_kind, output tx_byte, output sample_rate_hz,
                  output sample_count, output acq_span_ns, output last_of_run, input ready);
  modport sink   (input valid, input out_kind, input tx_byte, input sample_rate_hz,
                  input sample_count, input acq_span_ns, input last_of_run, output ready);
endinterface

### rtl/sump_command_decoder.sv
// output: a reply byte is registered from S_REPLY after its command is taken, a run request
// from S_RUN_OUT after S_DIV_RATE, S_PREP, S_DIV_PER and S_MUL; a reply stream moves one byte
// per cycle while ready stays high; input: settings and argument bytes one per cycle while idle;
// reply and run commands hold the input until their last output is registered, a run using the
// shared 31-step restoring divider once for the rate and, unless that is zero, once for the period
// reset: synchronous active low; clears all settings and sets the window cap to 10000 ms
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sump_command_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  sump_in_if.sink                    in_ch,
  sump_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [scd_pkg::CFG_W-1:0]  cfg_wdata
);
  import scd_pkg::*;

  localparam int DIV_W  = 31;
  localparam int DVSR_W = RATE_W;
  localparam int STEP_W = $clog2(DIV_W);
  localparam int PROD_W = DIV_W + CNT_W;
  localparam int IDX_W  = $clog2(META_LEN);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_REPLY    = 7'b0000010,
    S_DIV_RATE = 7'b0000100,
    S_PREP     = 7'b0001000,
    S_DIV_PER  = 7'b0010000,
    S_MUL      = 7'b0100000,
    S_RUN_OUT  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    REP_ID,
    REP_META,
    REP_ZERO
  } reply_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    max_win_r, max_win_nxt;
  logic [7:0]          pend_cmd_r, pend_cmd_nxt;
  logic [2:0]          seen_r, seen_nxt;
  logic [31:0]         arg_r, arg_nxt;
  logic [23:0]         divider_r, divider_nxt;
  logic [31:0]         flags_r, flags_nxt;
  logic [32:0]         rcount_r, rcount_nxt;
  logic                rc_given_r, rc_given_nxt;
  reply_t              reply_sel_r, reply_sel_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic [DVSR_W-1:0]   rem_r, rem_nxt;
  logic [DVSR_W-1:0]   dvsr_r, dvsr_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic                rate_zero_r, rate_zero_nxt;
  logic [CNT_W-1:0]    scount_r, scount_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [WIN_W-1:0]    cap_r, cap_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [TX_W-1:0]     out_tx_r, out_tx_nxt;
  logic [RATE_W-1:0]   out_rate_r, out_rate_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic [WIN_W-1:0]    out_win_r, out_win_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_ready;
  logic                in_acc;
  logic                out_free;
  logic                is_long;
  logic [1:0]          arg_pos;
  logic [31:0]         arg_full;
  logic [32:0]         rc_eff;
  logic [34:0]         rc_times4;
  logic [CNT_W-1:0]    cnt_sat;
  logic [DVSR_W:0]     div_shift;
  logic                div_ge;
  logic [DVSR_W:0]     div_diff;
  logic [DVSR_W-1:0]   rem_step;
  logic [DIV_W-1:0]    quo_step;
  logic [31:0]         rate_wide;
  logic [RATE_W-1:0]   rate_sat;
  logic [IDX_W-1:0]    reply_last;
  logic [TX_W-1:0]     reply_byte;

  // handshake
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // command class and argument assembly
  assign is_long  = in_ch.rx_byte inside {[8'h80:8'h9F], [8'hC0:8'hCF]};
  assign arg_pos  = seen_r[1:0] - 2'd1;
  assign arg_full = arg_r | (32'(in_ch.rx_byte) << {arg_pos, 3'b000});

  // sample count, saturated at the cap
  assign rc_eff    = rc_given_r ? rcount_r : 33'd256;
  assign rc_times4 = {rc_eff, 2'b00};
  assign cnt_sat   = (rc_times4 > 35'(SAMPLE_CAP)) ? CNT_W'(SAMPLE_CAP)
                                                   : rc_times4[CNT_W-1:0];

  // shared restoring divider step
  assign div_shift = {rem_r, quo_r[DIV_W-1]};
  assign div_ge    = (div_shift >= {1'b0, dvsr_r});
  assign div_diff  = div_shift - {1'b0, dvsr_r};
  assign rem_step  = div_ge ? div_diff[DVSR_W-1:0] : div_shift[DVSR_W-1:0];
  assign quo_step  = {quo_r[DIV_W-2:0], div_ge};

  // rate from the first quotient, doubled in demux mode and saturated
  assign rate_wide = flags_r[0] ? {quo_r, 1'b0} : {1'b0, quo_r};
  assign rate_sat  = (rate_wide > 32'(RATE_MAX)) ? RATE_MAX : rate_wide[RATE_W-1:0];

  // reply stream source
  assign reply_last = (reply_sel_r == REP_META) ? IDX_W'(META_LEN - 1) : IDX_W'(ID_LEN - 1);
  always_comb begin
    case (reply_sel_r)
      REP_ID:   reply_byte = id_byte(idx_r[1:0]);
      REP_META: reply_byte = meta_byte(idx_r);
      default:  reply_byte = '0;
    endcase
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    max_win_nxt   = max_win_r;
    pend_cmd_nxt  = pend_cmd_r;
    seen_nxt      = seen_r;
    arg_nxt       = arg_r;
    divider_nxt   = divider_r;
    flags_nxt     = flags_r;
    rcount_nxt    = rcount_r;
    rc_given_nxt  = rc_given_r;
    reply_sel_nxt = reply_sel_r;
    idx_nxt       = idx_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvsr_nxt      = dvsr_r;
    step_nxt      = step_r;
    rate_nxt      = rate_r;
    rate_zero_nxt = rate_zero_r;
    scount_nxt    = scount_r;
    prod_nxt      = prod_r;
    cap_nxt       = cap_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_tx_nxt    = out_tx_r;
    out_rate_nxt  = out_rate_r;
    out_cnt_nxt   = out_cnt_r;
    out_win_nxt   = out_win_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_we) begin
      max_win_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (seen_r != 3'd0) begin
            // argument byte of a long command
            arg_nxt  = arg_full;
            seen_nxt = seen_r + 3'd1;
            if (seen_r == 3'd4) begin
              seen_nxt = 3'd0;
              case (pend_cmd_r)
                CMD_DIVIDER: divider_nxt = arg_full[23:0];
                CMD_READ16: begin
                  rcount_nxt   = 33'(arg_full[15:0]) + 33'd1;
                  rc_given_nxt = 1'b1;
                end
                CMD_FLAGS:   flags_nxt = arg_full;
                CMD_READ32: begin
                  rcount_nxt   = 33'(arg_full) + 33'd1;
                  rc_given_nxt = 1'b1;
                end
                default: ;
              endcase
            end
          end else if (is_long) begin
            pend_cmd_nxt = in_ch.rx_byte;
            arg_nxt      = '0;
            seen_nxt     = 3'd1;
          end else begin
            case (in_ch.rx_byte)
              CMD_RESET: begin
                divider_nxt  = '0;
                flags_nxt    = '0;
                rcount_nxt   = '0;
                rc_given_nxt = 1'b0;
              end
              CMD_RUN: begin
                quo_nxt    = DIV_W'(CLOCK_HZ);
                dvsr_nxt   = DVSR_W'({1'b0, divider_r} + 25'd1);
                rem_nxt    = '0;
                step_nxt   = STEP_W'(DIV_W - 1);
                scount_nxt = cnt_sat;
                state_nxt  = S_DIV_RATE;
              end
              CMD_ID: begin
                reply_sel_nxt = REP_ID;
                idx_nxt       = '0;
                state_nxt     = S_REPLY;
              end
              CMD_META: begin
                reply_sel_nxt = REP_META;
                idx_nxt       = '0;
                state_nxt     = S_REPLY;
              end
              CMD_QUERY: begin
                reply_sel_nxt = REP_ZERO;
                idx_nxt       = '0;
                state_nxt     = S_REPLY;
              end
              default: ;
            endcase
          end
        end
      end

      // one reply byte per free output slot
      S_REPLY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_tx_nxt    = reply_byte;
          out_rate_nxt  = '0;
          out_cnt_nxt   = '0;
          out_win_nxt   = '0;
          out_last_nxt  = (idx_r == reply_last);
          idx_nxt       = idx_r + IDX_W'(1);
          if (idx_r == reply_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      // clock over divider plus one
      S_DIV_RATE: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = S_PREP;
        end
      end

      // latch the rate and set up the rounded-up period division
      S_PREP: begin
        rate_nxt      = rate_sat;
        rate_zero_nxt = (rate_sat == '0);
        quo_nxt       = DIV_W'(NS_PER_S) + DIV_W'(rate_sat) - DIV_W'(1);
        dvsr_nxt      = rate_sat;
        rem_nxt       = '0;
        step_nxt      = STEP_W'(DIV_W - 1);
        state_nxt     = (rate_sat == '0) ? S_MUL : S_DIV_PER;
      end

      S_DIV_PER: begin
        quo_nxt  = quo_step;
        rem_nxt  = rem_step;
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = S_MUL;
        end
      end

      // window product and cap in ns
      S_MUL: begin
        prod_nxt  = PROD_W'(quo_r) * PROD_W'(scount_r);
        cap_nxt   = WIN_W'(max_win_r) * WIN_W'(NS_PER_MS);
        state_nxt = S_RUN_OUT;
      end

      S_RUN_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_tx_nxt    = '0;
          out_rate_nxt  = rate_r;
          out_cnt_nxt   = scount_r;
          out_win_nxt   = (rate_zero_r || (prod_r > PROD_W'(cap_r))) ? cap_r
                                                                     : prod_r[WIN_W-1:0];
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control and settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_win_r   <= MAX_WIN_RESET;
      pend_cmd_r  <= '0;
      seen_r      <= '0;
      arg_r       <= '0;
      divider_r   <= '0;
      flags_r     <= '0;
      rcount_r    <= '0;
      rc_given_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_win_r   <= max_win_nxt;
      pend_cmd_r  <= pend_cmd_nxt;
      seen_r      <= seen_nxt;
      arg_r       <= arg_nxt;
      divider_r   <= divider_nxt;
      flags_r     <= flags_nxt;
      rcount_r    <= rcount_nxt;
      rc_given_r  <= rc_given_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and output payload registers
  always_ff @(posedge clk) begin
    reply_sel_r <= reply_sel_nxt;
    idx_r       <= idx_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    dvsr_r      <= dvsr_nxt;
    step_r      <= step_nxt;
    rate_r      <= rate_nxt;
    rate_zero_r <= rate_zero_nxt;
    scount_r    <= scount_nxt;
    prod_r      <= prod_nxt;
    cap_r       <= cap_nxt;
    out_kind_r  <= out_kind_nxt;
    out_tx_r    <= out_tx_nxt;
    out_rate_r  <= out_rate_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_win_r   <= out_win_nxt;
    out_last_r  <= out_last_nxt;
  end

  // ports
  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_kind       = out_kind_r;
  assign out_ch.tx_byte        = out_tx_r;
  assign out_ch.sample_rate_hz = out_rate_r;
  assign out_ch.sample_count   = out_cnt_r;
  assign out_ch.acq_span_ns    = out_win_r;
  assign out_ch.last_of_run    = out_last_r;

  // checks
  `SCD_ASSERT(a_run_starts_div, clk, rst_n, (in_acc && seen_r == 3'd0 && in_ch.rx_byte == CMD_RUN) |=> (state_r == S_DIV_RATE), "run command did not start the divider")
  `SCD_ASSERT(a_div_ends, clk, rst_n, (state_r == S_DIV_RATE && step_r == '0) |=> (state_r == S_PREP), "rate division overran its step count")
  `SCD_ASSERT(a_reply_last, clk, rst_n, (state_r == S_REPLY && state_nxt == S_IDLE) |=> (out_valid_r && out_last_r), "reply stream ended without a last transaction")
  `SCD_NEVER(a_run_single, clk, rst_n, out_valid_r && out_kind_r && !out_last_r, "acquisition request not marked last")

endmodule
